// File: hdl/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package afr_pkg;

    localparam logic [7:0]  DELIMITER      = 8'h7E;
    localparam logic [7:0]  CHECK_TARGET   = 8'hFF;
    localparam logic [16:0] COMMAND_POS    = 17'd15;
    localparam logic [16:0] DATA_START_POS = 17'd16;
    localparam logic [15:0] MIN_LENGTH     = 16'd13;
    localparam logic [16:0] HEADER_BYTES   = 17'd3;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd256;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY
    } t_phase;

    typedef enum logic [2:0] {
        K_COMMAND = 3'd0,
        K_DATA    = 3'd1,
        K_GOOD    = 3'd2,
        K_BAD_SUM = 3'd3,
        K_SHORT   = 3'd4,
        K_REJECT  = 3'd5
    } t_kind;

    typedef struct packed {
        logic        hit;
        t_kind       kind;
        logic [7:0]  byte_value;
        logic [15:0] data_index;
        logic        frame_end;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/afr_if.sv
// ----------------------------------------------------------------------------
// afr_byte_if / afr_result_if
// Valid/ready channels for received bytes and parsed result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface afr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface afr_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] data_index;
    logic        frame_end;

    modport source (output valid, output kind, output byte_value, output data_index,
                    output frame_end, input ready);
    modport sink (input valid, input kind, input byte_value, input data_index,
                  input frame_end, output ready);
endinterface

`default_nettype wire

// File: hdl/afr_parser.sv
// ----------------------------------------------------------------------------
// afr_parser
// Frame state machine: delimiter hunt, length, running sum, command/data and
// checksum verdict. Advances by one byte when i_step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    input  wire logic [15:0]     i_max_len,
    output afr_pkg::t_result     o_res
);
    import afr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [16:0] r_pos, n_pos;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_sum, n_sum;

    logic [15:0] len_full;
    logic        len_bad;
    logic [16:0] end_pos;
    logic        at_check;
    logic [7:0]  sum_next;
    logic [16:0] data_off;

    assign len_full = {r_len[15:8], i_byte};
    assign len_bad  = (len_full == 16'd0) || (len_full > i_max_len);
    assign end_pos  = HEADER_BYTES + {1'b0, r_len};
    assign at_check = (r_pos >= end_pos);
    assign sum_next = r_sum + i_byte;
    assign data_off = r_pos - DATA_START_POS;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_len   = r_len;
        n_sum   = r_sum;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == DELIMITER) begin
                    n_phase = PH_LEN_HI;
                    n_pos   = 17'd1;
                end
            end
            PH_LEN_HI: begin
                n_len   = {i_byte, 8'h00};
                n_phase = PH_LEN_LO;
                n_pos   = 17'd2;
            end
            PH_LEN_LO: begin
                n_len = len_full;
                if (len_bad) begin
                    n_phase = PH_HUNT;
                    n_pos   = 17'd0;
                end else begin
                    n_phase = PH_BODY;
                    n_pos   = HEADER_BYTES;
                    n_sum   = 8'd0;
                end
            end
            PH_BODY: begin
                if (at_check) begin
                    n_phase = PH_HUNT;
                    n_pos   = 17'd0;
                end else begin
                    n_sum = sum_next;
                    n_pos = r_pos + 17'd1;
                end
            end
        endcase
    end

    // result
    always_comb begin
        o_res = '{hit: 1'b0, kind: K_COMMAND, byte_value: 8'd0, data_index: 16'd0,
                  frame_end: 1'b0};
        unique case (r_phase) inside
            PH_HUNT, PH_LEN_HI: begin
                o_res.hit = 1'b0;
            end
            PH_LEN_LO: begin
                if (len_bad) begin
                    o_res.hit       = 1'b1;
                    o_res.kind      = K_REJECT;
                    o_res.frame_end = 1'b1;
                end
            end
            PH_BODY: begin
                if (at_check) begin
                    o_res.hit       = 1'b1;
                    o_res.frame_end = 1'b1;
                    if (r_len < MIN_LENGTH) begin
                        o_res.kind = K_SHORT;
                    end else if (sum_next == CHECK_TARGET) begin
                        o_res.kind = K_GOOD;
                    end else begin
                        o_res.kind = K_BAD_SUM;
                    end
                end else if (r_pos == COMMAND_POS) begin
                    o_res.hit        = 1'b1;
                    o_res.kind       = K_COMMAND;
                    o_res.byte_value = i_byte;
                end else if (r_pos >= DATA_START_POS) begin
                    o_res.hit        = 1'b1;
                    o_res.kind       = K_DATA;
                    o_res.byte_value = i_byte;
                    o_res.data_index = data_off[15:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_pos   <= 17'd0;
            r_len   <= 16'd0;
            r_sum   <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_sum   <= n_sum;
        end
    end

endmodule

`default_nettype wire

// File: hdl/api_frame_receiver.sv
// ----------------------------------------------------------------------------
// api_frame_receiver
// Delimited, length-prefixed, checksummed frame receiver.
//
// i_rx carries received link bytes, one per word. o_res carries one result
// word per command byte, data byte and frame verdict (good, bad checksum, too
// short, length rejected); header bytes and leading frame bytes give none.
// i_cfg_we / i_cfg_data write max_frame_length (256 after reset); write it
// only while no byte is in flight.
//
// A byte is captured in an input register, parsed in one pass when it advances
// out of it, and its result is held in the output register that drives o_res.
// One byte is accepted every cycle while o_res is taken; the output register
// lets the next byte be captured while a result waits. If o_res stalls, at
// most one more byte is held in the input register before i_rx.ready falls;
// nothing is dropped.
//
// Synchronous active-low reset empties both registers and returns the parser
// to hunting for the delimiter.
// ----------------------------------------------------------------------------
`default_nettype none

module api_frame_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    afr_byte_if.sink         i_rx,
    afr_result_if.source     o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data
);
    import afr_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_max_len;
    logic        advance;
    t_result     step_res;

    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    afr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_res     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_res.hit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res.hit) begin
            r_out <= step_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_out.kind;
    assign o_res.byte_value = r_out.byte_value;
    assign o_res.data_index = r_out.data_index;
    assign o_res.frame_end  = r_out.frame_end;

endmodule

`default_nettype wire
